### rtl/tlfs_pkg.sv
// Package for the two-level feedback scheduler: event codes, level codes, widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tlfs_pkg;
  localparam int unsigned MaxThreadsDef = 16;
  localparam int unsigned IdW  = 4;
  localparam int unsigned CfgW = 16;
  localparam int unsigned RemW = 17;

  localparam logic [2:0] FnAdd     = 3'd0;
  localparam logic [2:0] FnFinish  = 3'd1;
  localparam logic [2:0] FnBlock   = 3'd2;
  localparam logic [2:0] FnWakeOne = 3'd3;
  localparam logic [2:0] FnWakeAll = 3'd4;
  localparam logic [2:0] FnTick    = 3'd5;

  localparam logic [1:0] LvlIdle = 2'd0;
  localparam logic [1:0] LvlHigh = 2'd1;
  localparam logic [1:0] LvlLow  = 2'd2;

  localparam logic [1:0] CfgHigh = 2'd0;
  localparam logic [1:0] CfgLow  = 2'd1;
  localparam logic [1:0] CfgIntv = 2'd2;

  // one queued event between the front and the back
  typedef struct packed {
    logic [2:0]     func;
    logic [IdW-1:0] tid;
  } event_t;
endpackage
`default_nettype wire

### rtl/tlfs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(Depth)-1:0]  waddr_i,
  input  wire [Width-1:0]          wdata_i,
  input  wire [$clog2(Depth)-1:0]  raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/tlfs_front.sv
// Front end: takes events and holds them in a short queue for the back end.
// Depends on tlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       push_i,
  input  wire tlfs_pkg::event_t     ev_i,
  input  wire                       pop_i,
  output logic                      avail_o,
  output tlfs_pkg::event_t          ev_o
);
  import tlfs_pkg::*;
  // two-entry queue
  event_t     slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;

  assign avail_o = (cnt_q != 2'd0);
  assign ev_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

### rtl/tlfs_quantum.sv
// Quantum unit: restoring divider, one quotient bit per cycle, for both quanta.
// Depends on tlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_quantum (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          go_i,
  input  wire [tlfs_pkg::CfgW-1:0]     hi_ticks_i,
  input  wire [tlfs_pkg::CfgW-1:0]     lo_ticks_i,
  input  wire [tlfs_pkg::CfgW-1:0]     intv_i,
  output logic                         busy_o,
  output logic [tlfs_pkg::CfgW-1:0]    hi_q_o,
  output logic [tlfs_pkg::CfgW-1:0]    lo_q_o
);
  import tlfs_pkg::*;
  localparam int unsigned CW = $clog2(CfgW) + 1;
  logic [CW-1:0]   bit_q;
  logic            sel_q, act_q;
  logic [CfgW-1:0] num_q, quo_q, rem_q;
  logic [CfgW:0]   trial;

  assign busy_o = act_q | go_i;
  assign trial  = {rem_q, num_q[CfgW-1]} - {1'b0, intv_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; sel_q <= 1'b0; bit_q <= '0;
      hi_q_o <= '0; lo_q_o <= '0;
      num_q <= '0; quo_q <= '0; rem_q <= '0;
    end else if (go_i) begin
      act_q <= 1'b1; sel_q <= 1'b0; bit_q <= '0;
      num_q <= hi_ticks_i; quo_q <= '0; rem_q <= '0;
    end else if (act_q) begin
      num_q <= {num_q[CfgW-2:0], 1'b0};
      if (!trial[CfgW]) begin
        rem_q <= trial[CfgW-1:0];
        quo_q <= {quo_q[CfgW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CfgW-2:0], num_q[CfgW-1]};
        quo_q <= {quo_q[CfgW-2:0], 1'b0};
      end
      if (bit_q == CW'(CfgW - 1)) begin
        bit_q <= '0;
        if (!sel_q) begin
          hi_q_o <= (intv_i == '0) ? '1 : {quo_q[CfgW-2:0], ~trial[CfgW]};
          sel_q <= 1'b1;
          num_q <= lo_ticks_i; quo_q <= '0; rem_q <= '0;
        end else begin
          lo_q_o <= (intv_i == '0) ? '1 : {quo_q[CfgW-2:0], ~trial[CfgW]};
          act_q <= 1'b0;
        end
      end else begin
        bit_q <= bit_q + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### rtl/tlfs_back.sv
// Back end: carries out one event at a time on three thread queues and the
// per-thread tick store. Depends on tlfs_pkg and tlfs_ram.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_back #(
  parameter int unsigned MaxThreads = tlfs_pkg::MaxThreadsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        avail_i,
  input  wire tlfs_pkg::event_t      ev_i,
  output logic                       pop_o,
  input  wire [tlfs_pkg::CfgW-1:0]   hi_quant_i,
  input  wire [tlfs_pkg::CfgW-1:0]   lo_quant_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [tlfs_pkg::IdW-1:0]   cur_id_o,
  output logic [1:0]                 level_o,
  output logic                       err_o
);
  import tlfs_pkg::*;
  localparam int unsigned AW = (MaxThreads > 1) ? $clog2(MaxThreads) : 1;
  localparam int unsigned CW = $clog2(MaxThreads + 1);
  localparam logic [CW-1:0] Full = CW'(MaxThreads);
  localparam int unsigned NId = 1 << IdW;

  // sequencer states
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRead = 3'd1; // RAM reads issued
  localparam logic [2:0] SExec = 3'd2;
  localparam logic [2:0] SWake = 3'd3; // wake-all walk, read issued
  localparam logic [2:0] SWkWr = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic [2:0]   st_q;
  event_t       ev_q;
  logic [AW-1:0] hh_q, lh_q, bh_q;
  logic [CW-1:0] hc_q, lc_q, bc_q;
  logic [IdW-1:0] run_q;
  logic [1:0]   lvl_q;
  logic         err_q;

  // RAM ports
  logic          hwe, lwe, bwe, rwe;
  logic [AW-1:0] hwa, lwa, bwa;
  logic [IdW-1:0] hwd, lwd, bwd, rwa;
  logic [RemW-1:0] rwd;
  logic [IdW-1:0] hrd, lrd, brd;
  logic [RemW-1:0] rrd;

  tlfs_ram #(.Width(IdW), .Depth(MaxThreads)) u_hq (.clk_i, .we_i(hwe),
    .waddr_i(hwa), .wdata_i(hwd), .raddr_i(hh_q), .rdata_o(hrd));
  tlfs_ram #(.Width(IdW), .Depth(MaxThreads)) u_lq (.clk_i, .we_i(lwe),
    .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lh_q), .rdata_o(lrd));
  tlfs_ram #(.Width(IdW), .Depth(MaxThreads)) u_bq (.clk_i, .we_i(bwe),
    .waddr_i(bwa), .wdata_i(bwd), .raddr_i(bh_q), .rdata_o(brd));
  tlfs_ram #(.Width(RemW), .Depth(NId)) u_rem (.clk_i, .we_i(rwe),
    .waddr_i(rwa), .wdata_i(rwd), .raddr_i(run_q), .rdata_o(rrd));

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] c);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, c};
    if (s >= {1'b0, Full}) s = s - {1'b0, Full};
    return s[AW-1:0];
  endfunction
  function automatic logic [AW-1:0] inc(input logic [AW-1:0] h);
    return (h == AW'(MaxThreads - 1)) ? '0 : h + 1'b1;
  endfunction

  // tick arithmetic
  logic [RemW-1:0] r_dec;
  logic expire, preempt;
  assign r_dec   = rrd - 1'b1;
  assign expire  = r_dec[RemW-1] || (r_dec == '0);
  assign preempt = !expire && (lvl_q == LvlLow) && (hc_q != '0);

  assign pop_o   = (st_q == SIdle) && avail_i;
  assign busy_o  = (st_q != SIdle) || avail_i;
  assign done_o  = (st_q == SDone);
  assign cur_id_o = (lvl_q != LvlIdle) ? run_q : '0;
  assign level_o = lvl_q;
  assign err_o   = err_q;

  // next-state of the queue control
  logic [2:0]     st_d;
  logic [AW-1:0]  hh_d, lh_d, bh_d;
  logic [CW-1:0]  hc_d, lc_d, bc_d;
  logic [IdW-1:0] run_d;
  logic [1:0]     lvl_d;
  logic           err_d;
  logic           pick;

  always_comb begin
    st_d = st_q; hh_d = hh_q; lh_d = lh_q; bh_d = bh_q;
    hc_d = hc_q; lc_d = lc_q; bc_d = bc_q;
    run_d = run_q; lvl_d = lvl_q; err_d = err_q;
    hwe = 1'b0; lwe = 1'b0; bwe = 1'b0; rwe = 1'b0;
    hwa = wrap(hh_q, hc_q); lwa = wrap(lh_q, lc_q); bwa = wrap(bh_q, bc_q);
    hwd = ev_q.tid; lwd = run_q; bwd = run_q;
    rwa = ev_q.tid; rwd = {1'b0, hi_quant_i};
    pick = 1'b0;
    case (st_q)
      SIdle: if (avail_i) st_d = SRead;
      SRead: st_d = SExec;
      SExec: begin
        st_d = SDone; err_d = 1'b0;
        case (ev_q.func)
          FnAdd: begin
            if (hc_q == Full) err_d = 1'b1;
            else begin
              hwe = 1'b1; rwe = 1'b1; hc_d = hc_q + 1'b1;
            end
          end
          FnFinish: pick = 1'b1;
          FnBlock: begin
            if (lvl_q == LvlIdle || bc_q == Full) err_d = 1'b1;
            else begin
              bwe = 1'b1; bc_d = bc_q + 1'b1; pick = 1'b1;
            end
          end
          FnWakeOne: begin
            if (bc_q == '0 || hc_q == Full) err_d = 1'b1;
            else begin
              hwe = 1'b1; hwd = brd; rwe = 1'b1; rwa = brd;
              hc_d = hc_q + 1'b1; bh_d = inc(bh_q); bc_d = bc_q - 1'b1;
            end
          end
          FnWakeAll: begin
            if (bc_q == '0 || ({1'b0, hc_q} + {1'b0, bc_q}) > {1'b0, Full})
              err_d = 1'b1;
            else st_d = SWkWr;
          end
          FnTick: begin
            if (lvl_q == LvlIdle) pick = 1'b1;
            else if ((expire || preempt) && lc_q == Full) err_d = 1'b1;
            else begin
              rwe = 1'b1; rwa = run_q; rwd = r_dec;
              if (expire || preempt) begin
                lwe = 1'b1; lc_d = lc_q + 1'b1; rwd = {1'b0, lo_quant_i};
                pick = 1'b1;
              end
            end
          end
          default: err_d = 1'b1;
        endcase
        if (pick) begin
          if (hc_q != '0) begin
            run_d = hrd; lvl_d = LvlHigh; hh_d = inc(hh_q); hc_d = hc_d - 1'b1;
          end else if (lc_d != '0) begin
            // a thread just demoted into an empty low queue comes straight back
            run_d = (lc_q != '0) ? lrd : run_q; lvl_d = LvlLow; lh_d = inc(lh_q);
            lc_d = lc_d - 1'b1;
          end else begin
            run_d = '0; lvl_d = LvlIdle;
          end
        end
      end
      SWkWr: begin
        // brd holds the current blocked head
        hwe = 1'b1; hwd = brd; rwe = 1'b1; rwa = brd;
        hc_d = hc_q + 1'b1; bh_d = inc(bh_q); bc_d = bc_q - 1'b1;
        st_d = (bc_q == CW'(1)) ? SDone : SWake;
      end
      SWake: st_d = SWkWr;
      SDone: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) ev_q <= ev_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; hh_q <= '0; lh_q <= '0; bh_q <= '0;
      hc_q <= '0; lc_q <= '0; bc_q <= '0;
      run_q <= '0; lvl_q <= LvlIdle; err_q <= 1'b0;
    end else begin
      st_q <= st_d; hh_q <= hh_d; lh_q <= lh_d; bh_q <= bh_d;
      hc_q <= hc_d; lc_q <= lc_d; bc_q <= bc_d;
      run_q <= run_d; lvl_q <= lvl_d; err_q <= err_d;
    end
  end
endmodule
`default_nettype wire

### rtl/two_level_feedback_scheduler.sv
// Top level of the two-level feedback scheduler.
// Depends on tlfs_pkg, tlfs_front, tlfs_back, tlfs_quantum, tlfs_ram.
//
//   port group   direction  handshake
//   event        in         start & !busy ; func_i, thread_id_i
//   result       out        done_o strobe, one cycle ; current_id_o .. error_o
//   config       in         cfg_we_i ; cfg_idx_i, cfg_data_i
//
// An event passes through the queue, a RAM read, execute and the strobe; the next event is
// accepted once busy falls after the strobe. Wake all adds a write and a read state
// per blocked thread, set by the registered read of the blocked queue RAM for each new head.
// A config write runs the bit-serial divider for both quanta; busy is high while it runs.
// Reset clears all queues and control; the tick store holds no reset value.
// The receiver cannot stall; busy stalls the sender.
`timescale 1ns / 1ps
`default_nettype none
module two_level_feedback_scheduler #(
  parameter int unsigned MaxThreads = tlfs_pkg::MaxThreadsDef
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  wire [2:0]                  func_i,
  input  wire [tlfs_pkg::IdW-1:0]    thread_id_i,
  output logic                       done_o,
  output logic [tlfs_pkg::IdW-1:0]   current_id_o,
  output logic                       running_o,
  output logic [1:0]                 level_o,
  output logic                       error_o,
  input  wire                        cfg_we_i,
  input  wire [1:0]                  cfg_idx_i,
  input  wire [tlfs_pkg::CfgW-1:0]   cfg_data_i
);
  import tlfs_pkg::*;

  logic [CfgW-1:0] hi_ticks_q, lo_ticks_q, intv_q;
  logic [CfgW-1:0] hi_ticks_d, lo_ticks_d, intv_d;
  logic [CfgW-1:0] hi_quant, lo_quant;
  logic            div_busy, back_busy, avail, pop, accept, cfg_hit;
  event_t          ev_in, ev_q;

  assign accept = start && !busy;
  assign ev_in  = '{func: func_i, tid: thread_id_i};
  assign cfg_hit = cfg_we_i && (cfg_idx_i inside {CfgHigh, CfgLow, CfgIntv});

  // configuration registers
  always_comb begin
    hi_ticks_d = hi_ticks_q; lo_ticks_d = lo_ticks_q; intv_d = intv_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgHigh: hi_ticks_d = cfg_data_i;
        CfgLow:  lo_ticks_d = cfg_data_i;
        CfgIntv: intv_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_ticks_q <= '0; lo_ticks_q <= '0; intv_q <= CfgW'(1);
    end else begin
      hi_ticks_q <= hi_ticks_d; lo_ticks_q <= lo_ticks_d; intv_q <= intv_d;
    end
  end

  tlfs_quantum u_quant (
    .clk_i, .rst_ni, .go_i(cfg_hit),
    .hi_ticks_i(hi_ticks_d), .lo_ticks_i(lo_ticks_d), .intv_i(intv_d),
    .busy_o(div_busy), .hi_q_o(hi_quant), .lo_q_o(lo_quant)
  );

  tlfs_front u_front (
    .clk_i, .rst_ni, .push_i(accept), .ev_i(ev_in),
    .pop_i(pop), .avail_o(avail), .ev_o(ev_q)
  );

  tlfs_back #(.MaxThreads(MaxThreads)) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .ev_i(ev_q), .pop_o(pop),
    .hi_quant_i(hi_quant), .lo_quant_i(lo_quant),
    .busy_o(back_busy), .done_o(done_o), .cur_id_o(current_id_o),
    .level_o(level_o), .err_o(error_o)
  );

  assign busy      = back_busy || div_busy;
  assign running_o = (level_o != LvlIdle);

`ifndef SYNTHESIS
  // no event enters while the front queue still holds one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !accept) else $error("event accepted back to back");
  // the level never shows the unused code
  a_level_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_o != 2'd3) else $error("bad level");
  // idle shows thread zero
  a_idle_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_o == LvlIdle) |-> (current_id_o == '0)) else $error("idle id");
  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
`endif
endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for the two-level feedback scheduler.
// Depends on tlfs_pkg and two_level_feedback_scheduler; predicts each result in a scoreboard.
`timescale 1ns / 1ps
module testbench;
  import tlfs_pkg::*;

  // func codes that the block does not know
  localparam logic [2:0] FnUndefA = 3'd6;
  localparam logic [2:0] FnUndefB = 3'd7;
  localparam int unsigned QDepth = MaxThreadsDef;
  localparam int unsigned StallLimit = 5000;

  typedef struct packed {
    logic [IdW-1:0] cur_id;
    logic           running;
    logic [1:0]     level;
    logic           error;
  } sched_res_t;

  // scheduler state mirror and queue of expected results
  class sched_scoreboard;
    logic [IdW-1:0] high_q[$];
    logic [IdW-1:0] low_q[$];
    logic [IdW-1:0] blocked_q[$];
    int             ticks_left[16];
    logic [IdW-1:0] run_id;
    logic [1:0]     run_lvl;
    int unsigned    hi_ticks, lo_ticks, interval, hi_quant, lo_quant;
    sched_res_t     pending_res[$];
    int             n_fail, n_events, n_errors, n_checked;

    function new();
      run_id = '0;
      run_lvl = LvlIdle;
      hi_ticks = 0;
      lo_ticks = 0;
      interval = 1;
      hi_quant = 0;
      lo_quant = 0;
      foreach (ticks_left[i]) ticks_left[i] = 0;
    endfunction

    function int unsigned quantum_for(int unsigned t);
      return (interval == 0) ? 32'hFFFF : t / interval;
    endfunction

    function void configure(logic [1:0] idx, logic [CfgW-1:0] val);
      case (idx)
        CfgHigh: hi_ticks = val;
        CfgLow:  lo_ticks = val;
        CfgIntv: interval = val;
        default: return;
      endcase
      hi_quant = quantum_for(hi_ticks);
      lo_quant = quantum_for(lo_ticks);
    endfunction

    function void pick_next();
      if (high_q.size() != 0) begin
        run_id = high_q[0];
        high_q.delete(0);
        run_lvl = LvlHigh;
      end else if (low_q.size() != 0) begin
        run_id = low_q[0];
        low_q.delete(0);
        run_lvl = LvlLow;
      end else begin
        run_id = '0;
        run_lvl = LvlIdle;
      end
    endfunction

    function void make_ready(logic [IdW-1:0] id);
      ticks_left[id] = hi_quant;
      high_q = {high_q, id};
    endfunction

    function void demote();
      ticks_left[run_id] = lo_quant;
      low_q = {low_q, run_id};
    endfunction

    function bit tick();
      bit expire, preempt;
      int r;
      expire = 0;
      preempt = 0;
      if (run_lvl != LvlIdle) begin
        r = ticks_left[run_id] - 1;
        expire = (r <= 0);
        if (!expire) preempt = (run_lvl == LvlLow && high_q.size() != 0);
        if ((expire || preempt) && low_q.size() >= QDepth) return 0;
        ticks_left[run_id] = r;
      end
      if (run_lvl == LvlIdle) pick_next();
      else if (expire) begin
        demote();
        pick_next();
      end else if (preempt) begin
        demote();
        run_id = high_q[0];
        high_q.delete(0);
        run_lvl = LvlHigh;
      end
      return 1;
    endfunction

    // an accepted event: advance the mirror and queue its result
    function void note_event(logic [2:0] fn, logic [IdW-1:0] tid);
      bit ok;
      sched_res_t r;
      logic [IdW-1:0] woken;
      ok = 1;
      case (fn)
        FnAdd:
          if (high_q.size() >= QDepth) ok = 0;
          else make_ready(tid);
        FnFinish: pick_next();
        FnBlock:
          if (run_lvl == LvlIdle || blocked_q.size() >= QDepth) ok = 0;
          else begin
            blocked_q = {blocked_q, run_id};
            pick_next();
          end
        FnWakeOne:
          if (blocked_q.size() == 0 || high_q.size() >= QDepth) ok = 0;
          else begin
            woken = blocked_q[0];
            blocked_q.delete(0);
            make_ready(woken);
          end
        FnWakeAll:
          if (blocked_q.size() == 0 || high_q.size() + blocked_q.size() > QDepth) ok = 0;
          else while (blocked_q.size() != 0) begin
            woken = blocked_q[0];
            blocked_q.delete(0);
            make_ready(woken);
          end
        FnTick: ok = tick();
        default: ok = 0;
      endcase
      r.running = (run_lvl != LvlIdle);
      r.cur_id  = r.running ? run_id : '0;
      r.level   = run_lvl;
      r.error   = !ok;
      pending_res = {pending_res, r};
      n_events++;
      if (!ok) n_errors++;
    endfunction

    function void check_result(sched_res_t got);
      sched_res_t want;
      if (pending_res.size() == 0) begin
        $display("%0t: result with nothing expected: id %0d run %0b lvl %0d err %0b",
                 $time, got.cur_id, got.running, got.level, got.error);
        n_fail++;
        return;
      end
      want = pending_res[0];
      pending_res.delete(0);
      n_checked++;
      if (got.cur_id !== want.cur_id) begin
        $display("%0t: current_id expected %0d actual %0d", $time, want.cur_id, got.cur_id);
        n_fail++;
      end
      if (got.running !== want.running) begin
        $display("%0t: running expected %0b actual %0b", $time, want.running, got.running);
        n_fail++;
      end
      if (got.level !== want.level) begin
        $display("%0t: level expected %0d actual %0d", $time, want.level, got.level);
        n_fail++;
      end
      if (got.error !== want.error) begin
        $display("%0t: error expected %0b actual %0b", $time, want.error, got.error);
        n_fail++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           start = 1'b0;
  logic [2:0]     func_i = FnAdd;
  logic [IdW-1:0] thread_id_i = '0;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = CfgHigh;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic           busy, done_o, running_o, error_o;
  logic [IdW-1:0] current_id_o;
  logic [1:0]     level_o;

  sched_scoreboard sb = new();
  int stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  two_level_feedback_scheduler dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .thread_id_i, .done_o,
    .current_id_o, .running_o, .level_o, .error_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // note accepted items, check strobed results, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_event(func_i, thread_id_i);
      if (done_o) sb.check_result({current_id_o, running_o, level_o, error_o});
      if ((start && !busy) || done_o || cfg_we_i) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("%0t: no progress for %0d cycles", $time, StallLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // one event; called and returning at a falling edge
  task automatic send_event(logic [2:0] fn, logic [IdW-1:0] tid, int gap_pct);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    func_i = fn;
    thread_id_i = tid;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (sb.pending_res.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [CfgW-1:0] val);
    cfg_idx_i = idx;
    cfg_data_i = val;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.configure(idx, val);
    // divider runs; let busy rise, then wait for it to fall
    repeat (2) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_quanta(logic [CfgW-1:0] hi, logic [CfgW-1:0] lo, logic [CfgW-1:0] iv);
    wait_drained();
    write_cfg(CfgHigh, hi);
    write_cfg(CfgLow, lo);
    write_cfg(CfgIntv, iv);
  endtask

  // weighted random event; add_bias pushes queues towards full
  task automatic random_event(int add_bias, int gap_pct);
    int p;
    logic [2:0] fn;
    p = $urandom_range(99);
    if (p < 25 + add_bias)      fn = FnAdd;
    else if (p < 55 + add_bias) fn = FnTick;
    else if (p < 65 + add_bias) fn = FnBlock;
    else if (p < 75 + add_bias) fn = FnWakeOne;
    else if (p < 83 + add_bias) fn = FnWakeAll;
    else if (p < 95)            fn = FnFinish;
    else                        fn = $urandom_range(1) ? FnUndefA : FnUndefB;
    send_event(fn, 4'($urandom_range(15)), gap_pct);
  endtask

  initial begin
    logic [CfgW-1:0] cfg_set[5][3];
    int gap;
    cfg_set = '{'{16'd3, 16'd2, 16'd1}, '{16'd0, 16'd0, 16'd1},
                '{16'hFFFF, 16'hFFFF, 16'd1}, '{16'd10, 16'd7, 16'd0},
                '{16'hFFFF, 16'd1, 16'hFFFF}};
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: illegal and idle events on an empty scheduler, then a short life cycle
    send_event(FnBlock, 4'd0, 0);
    send_event(FnWakeOne, 4'd0, 0);
    send_event(FnWakeAll, 4'd0, 0);
    send_event(FnFinish, 4'd0, 0);
    send_event(FnTick, 4'd0, 0);
    send_event(FnUndefA, 4'hF, 0);
    send_event(FnUndefB, 4'h0, 0);
    send_event(FnAdd, 4'hF, 0);
    send_event(FnAdd, 4'h0, 0);
    send_event(FnAdd, 4'h5, 0);
    send_event(FnTick, 4'h0, 0);
    send_event(FnBlock, 4'h0, 0);
    send_event(FnBlock, 4'h0, 0);
    send_event(FnWakeOne, 4'h0, 0);
    send_event(FnTick, 4'h0, 0);
    send_event(FnBlock, 4'h0, 0);
    send_event(FnWakeAll, 4'h0, 0);
    send_event(FnTick, 4'h0, 0);
    send_event(FnTick, 4'h0, 0);
    send_event(FnFinish, 4'h0, 0);
    send_event(FnAdd, 4'hA, 0);
    send_event(FnTick, 4'h0, 0);

    // random phases across quantum settings and sender idling
    for (int ph = 0; ph < 5; ph++) begin
      set_quanta(cfg_set[ph][0], cfg_set[ph][1], cfg_set[ph][2]);
      for (int i = 0; i < 185; i++) begin
        case ((ph + i / 60) % 3)
          0: gap = 0;
          1: gap = 46;
          default: gap = 23;
        endcase
        random_event((i / 30) % 2 ? 15 : 0, gap);
        if (i == 90 && ph == 1) wait_drained();
      end
    end

    start = 1'b0;
    while (sb.pending_res.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (sb.pending_res.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending_res.size());
      sb.n_fail++;
    end
    $display("Covered %0d events (%0d flagged illegal), %0d results checked,",
             sb.n_events, sb.n_errors, sb.n_checked);
    $display("over five quantum settings including zero and full-scale intervals.");
    if (sb.n_fail == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
